@@ design/graphics_tag_packet_parser_assert.svh @@
// Assertion macros used by the checker file of the tag packet parser.
`ifndef GRAPHICS_TAG_PACKET_PARSER_ASSERT_SVH
`define GRAPHICS_TAG_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GTPP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gtpp assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GTPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gtpp assertion failed");

`endif

@@ design/gtpp_pkg.sv @@
// Package with the types, codes and constants of the tag packet parser.
package gtpp_pkg;

    // Number of logical qword paths and the address width of the path state store.
    localparam int PATH_COUNT = 3;
    localparam int PATH_AW    = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;

    // Register number that turns a packed write into an address-data write.
    localparam logic [3:0] ADDR_DATA_REG = 4'he;
    // Register count when the tag count code is zero.
    localparam logic [4:0] MAX_REGS      = 5'd16;
    // Saturation value of the fragment counter.
    localparam logic [15:0] FRAG_MAX     = 16'hffff;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_TAG       = 3'd0,
        KIND_PACKED    = 3'd1,
        KIND_ADDR_DATA = 3'd2,
        KIND_REGLIST   = 3'd3,
        KIND_IMAGE     = 3'd4
    } t_item_kind;

    // Data modes from the tag; both remaining codes mean image.
    typedef enum logic [1:0] {
        MODE_PACKED  = 2'd0,
        MODE_REGLIST = 2'd1,
        MODE_IMAGE   = 2'd2,
        MODE_IMAGE_B = 2'd3
    } t_data_mode;

    // One entry of the per-path state store.
    typedef struct packed {
        logic [14:0] loops_left;
        logic [3:0]  reg_position;
        logic        end_of_packet;
        t_data_mode  data_mode;
        logic [3:0]  reg_count_code;
        logic [63:0] reg_descriptor;
    } t_path_state;

    // State of a path that has never been written.
    localparam t_path_state PATH_STATE_RESET = '{
        loops_left:     15'd0,
        reg_position:   4'd0,
        end_of_packet:  1'b1,
        data_mode:      MODE_PACKED,
        reg_count_code: 4'd0,
        reg_descriptor: 64'd0
    };

    // Labels the step logic produces for one qword.
    typedef struct packed {
        t_item_kind  kind;
        logic [7:0]  reg_first;
        logic [3:0]  reg_second;
        logic        second_valid;
        logic        packet_done;
    } t_result;

endpackage

@@ design/gtpp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module gtpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read of the written entry returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/gtpp_step.sv @@
// Per-qword update of one path's state and the labels of the qword.
module gtpp_step (
    input  gtpp_pkg::t_path_state i_state,
    input  logic [63:0]           i_qword_low,
    input  logic [63:0]           i_qword_high,
    output gtpp_pkg::t_path_state o_state,
    output gtpp_pkg::t_result     o_result
);

    typedef struct packed {
        logic [3:0]  pos;
        logic [14:0] loops;
    } t_pos_loops;

    // Step one register along the list; the wrap counts down one loop.
    function automatic t_pos_loops adv_reg(input logic [3:0] pos, input logic [14:0] loops,
                                           input logic [4:0] total);
        logic [4:0] nx;
        t_pos_loops r;
        nx = {1'b0, pos} + 5'd1;
        if (nx >= total) begin
            r.pos   = 4'd0;
            r.loops = (loops != 15'd0) ? loops - 15'd1 : loops;
        end else begin
            r.pos   = nx[3:0];
            r.loops = loops;
        end
        return r;
    endfunction

    logic [4:0]  total;
    logic [3:0]  cur_reg;
    t_pos_loops  step_a;
    t_pos_loops  step_b;
    logic [3:0]  next_reg;

    // List length, current register and the two possible register steps.
    always_comb begin
        total    = (i_state.reg_count_code == 4'd0) ? gtpp_pkg::MAX_REGS
                                                    : {1'b0, i_state.reg_count_code};
        cur_reg  = i_state.reg_descriptor[{i_state.reg_position, 2'b00} +: 4];
        step_a   = adv_reg(i_state.reg_position, i_state.loops_left, total);
        next_reg = i_state.reg_descriptor[{step_a.pos, 2'b00} +: 4];
        step_b   = adv_reg(step_a.pos, step_a.loops, total);
    end

    // Tag load or data labelling by mode.
    always_comb begin
        o_state  = i_state;
        o_result = '{kind: gtpp_pkg::KIND_TAG, reg_first: 8'd0, reg_second: 4'd0,
                     second_valid: 1'b0, packet_done: 1'b0};
        if (i_state.loops_left == 15'd0) begin
            o_state.loops_left     = i_qword_low[14:0];
            o_state.end_of_packet  = i_qword_low[15];
            o_state.data_mode      = gtpp_pkg::t_data_mode'(i_qword_low[59:58]);
            o_state.reg_count_code = i_qword_low[63:60];
            o_state.reg_descriptor = i_qword_high;
            o_state.reg_position   = 4'd0;
        end else begin
            unique case (i_state.data_mode)
                gtpp_pkg::MODE_PACKED: begin
                    if (cur_reg == gtpp_pkg::ADDR_DATA_REG) begin
                        o_result.kind      = gtpp_pkg::KIND_ADDR_DATA;
                        o_result.reg_first = i_qword_high[7:0];
                    end else begin
                        o_result.kind      = gtpp_pkg::KIND_PACKED;
                        o_result.reg_first = {4'd0, cur_reg};
                    end
                    o_state.reg_position = step_a.pos;
                    o_state.loops_left   = step_a.loops;
                end
                gtpp_pkg::MODE_REGLIST: begin
                    o_result.kind      = gtpp_pkg::KIND_REGLIST;
                    o_result.reg_first = {4'd0, cur_reg};
                    if (step_a.loops != 15'd0) begin
                        o_result.reg_second   = next_reg;
                        o_result.second_valid = 1'b1;
                        o_state.reg_position  = step_b.pos;
                        o_state.loops_left    = step_b.loops;
                    end else begin
                        o_state.reg_position  = step_a.pos;
                        o_state.loops_left    = step_a.loops;
                    end
                end
                gtpp_pkg::MODE_IMAGE, gtpp_pkg::MODE_IMAGE_B: begin
                    o_result.kind      = gtpp_pkg::KIND_IMAGE;
                    o_state.loops_left = i_state.loops_left - 15'd1;
                end
                default: begin
                    o_result.kind = gtpp_pkg::KIND_TAG;
                end
            endcase
        end
        o_result.packet_done = o_state.end_of_packet && (o_state.loops_left == 15'd0);
    end

endmodule

@@ design/graphics_tag_packet_parser.sv @@
// Top level of the tag packet parser: path state store, update stage and output register.
//
//   channel   dir  tdata                              tuser                 tlast
//   s_axis    in   qword_low, qword_high              path_select           fragment_last
//   m_axis    out  reg_first, reg_second, data_low,   item_kind, path_out,  packet_done
//                  data_high, fragment_count          second_valid
//
// One qword per cycle while the output accepts; a request goes from input to output through
// a read of the path state store, then the update stage, which writes back and loads
// the output register. A write back to the path read by the next request is forwarded.
// Reset is synchronous; per-path valid bits make unwritten entries read as the reset state.
// A stalled output holds one result and one request in the update stage before input stalls.
module graphics_tag_packet_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] qword_low, [127:64] qword_high
    input  logic [1:0]   s_axis_tuser,   // [1:0] path_select
    input  logic         s_axis_tlast,   // fragment_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // [7:0] reg_first, [11:8] reg_second,
                                         // [75:12] data_low, [139:76] data_high,
                                         // [155:140] fragment_count, [159:156] zero
    output logic [5:0]   m_axis_tuser,   // [2:0] item_kind, [4:3] path_out, [5] second_valid
    output logic         m_axis_tlast    // packet_done
);

    localparam int AW = gtpp_pkg::PATH_AW;
    localparam int SW = $bits(gtpp_pkg::t_path_state);
    localparam int PATH_COUNT_L = gtpp_pkg::PATH_COUNT;

    logic                  in_accept;
    logic                  advance;
    logic [1:0]            in_path;
    logic [AW-1:0]         in_addr;

    logic                  r_s1_valid;
    logic [1:0]            r_s1_path;
    logic [AW-1:0]         r_s1_addr;
    logic [63:0]           r_s1_lo;
    logic [63:0]           r_s1_hi;
    logic                  r_s1_last;
    logic                  r_s1_hit;
    logic                  r_s1_mvalid;
    gtpp_pkg::t_path_state r_s1_fwd;

    logic [PATH_COUNT_L-1:0] r_valid;

    logic [SW-1:0]         ram_rdata;
    gtpp_pkg::t_path_state cur_state;
    gtpp_pkg::t_path_state nxt_state;
    gtpp_pkg::t_result     result;

    logic [15:0]           r_frag_cnt;
    logic [15:0]           frag_inc;

    logic                  r_out_valid;
    gtpp_pkg::t_result     r_out_res;
    logic [1:0]            r_out_path;
    logic [63:0]           r_out_lo;
    logic [63:0]           r_out_hi;
    logic [15:0]           r_out_cnt;

    // Handshake: the update stage moves on when the output register is free or drains.
    assign advance       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Out-of-range paths fold onto the last path.
    assign in_path = ({1'b0, s_axis_tuser} >= 3'(gtpp_pkg::PATH_COUNT))
                   ? 2'(gtpp_pkg::PATH_COUNT - 1) : s_axis_tuser;
    assign in_addr = in_path[AW-1:0];

    gtpp_ram #(
        .WIDTH (SW),
        .DEPTH (gtpp_pkg::PATH_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_s1_addr),
        .i_wdata (nxt_state),
        .i_re    (in_accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // State seen by the update stage: forwarded write, stored entry or reset state.
    always_comb begin
        if (r_s1_hit) begin
            cur_state = r_s1_fwd;
        end else if (r_s1_mvalid) begin
            cur_state = gtpp_pkg::t_path_state'(ram_rdata);
        end else begin
            cur_state = gtpp_pkg::PATH_STATE_RESET;
        end
    end

    gtpp_step u_step (
        .i_state      (cur_state),
        .i_qword_low  (r_s1_lo),
        .i_qword_high (r_s1_hi),
        .o_state      (nxt_state),
        .o_result     (result)
    );

    // Saturating fragment count including the current qword.
    assign frag_inc = (r_frag_cnt < gtpp_pkg::FRAG_MAX) ? r_frag_cnt + 16'd1 : r_frag_cnt;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_frag_cnt  <= 16'd0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid        <= 1'b1;
                r_valid[r_s1_addr] <= 1'b1;
                r_frag_cnt         <= r_s1_last ? 16'd0 : frag_inc;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Update stage payload, with the forwarding check against the write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_path   <= in_path;
            r_s1_addr   <= in_addr;
            r_s1_lo     <= s_axis_tdata[63:0];
            r_s1_hi     <= s_axis_tdata[127:64];
            r_s1_last   <= s_axis_tlast;
            r_s1_hit    <= advance && (r_s1_addr == in_addr);
            r_s1_fwd    <= nxt_state;
            r_s1_mvalid <= r_valid[in_addr];
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res  <= result;
            r_out_path <= r_s1_path;
            r_out_lo   <= r_s1_lo;
            r_out_hi   <= r_s1_hi;
            r_out_cnt  <= frag_inc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_cnt, r_out_hi, r_out_lo,
                            r_out_res.reg_second, r_out_res.reg_first};
    assign m_axis_tuser  = {r_out_res.second_valid, r_out_path, r_out_res.kind};
    assign m_axis_tlast  = r_out_res.packet_done;

endmodule

@@ design/gtpp_checker.sv @@
// Port-level checker for the tag packet parser and its bind to the top level.
`include "graphics_tag_packet_parser_assert.svh"

module gtpp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [5:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // A stalled result stays offered and unchanged.
    `GTPP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // A second register is only reported on a reglist pair.
    `GTPP_ASSERT_NOW(a_second_kind, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[5], m_axis_tuser[2:0] == gtpp_pkg::KIND_REGLIST)

    // Padding or non-reglist results carry no second register number.
    `GTPP_ASSERT_NOW(a_second_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[5], m_axis_tdata[11:8] == 4'd0)

    // Every result counts at least its own qword in the fragment.
    `GTPP_ASSERT_NOW(a_frag_nonzero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[155:140] != 16'd0)

endmodule

bind graphics_tag_packet_parser gtpp_checker u_gtpp_checker (.*);

@@ tb/sv/graphics_tag_packet_parser_tb.sv @@
// Self-checking testbench for the tag packet parser: directed packets, random traffic and back-pressure.
module graphics_tag_packet_parser_tb;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1000;

    // Labels the parser is expected to put on one qword.
    typedef struct {
        gtpp_pkg::t_item_kind kind;
        logic [1:0]  path;
        logic [7:0]  reg_first;
        logic [3:0]  reg_second;
        logic        second_valid;
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic        packet_done;
        logic [15:0] fragment_count;
    } t_qword_label;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;   // [63:0] qword_low, [127:64] qword_high
    logic [1:0]   s_axis_tuser  = '0;   // [1:0] path_select
    logic         s_axis_tlast  = 1'b0; // fragment_last
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;         // [7:0] reg_first, [11:8] reg_second, [75:12] data_low,
                                        // [139:76] data_high, [155:140] fragment_count
    logic [5:0]   m_axis_tuser;         // [2:0] item_kind, [4:3] path_out, [5] second_valid
    logic         m_axis_tlast;         // packet_done

    // Per-path parser state as the block should hold it.
    logic [14:0] path_loops      [gtpp_pkg::PATH_COUNT];
    logic [3:0]  path_reg_pos    [gtpp_pkg::PATH_COUNT];
    logic        path_eop        [gtpp_pkg::PATH_COUNT];
    gtpp_pkg::t_data_mode path_mode [gtpp_pkg::PATH_COUNT];
    logic [3:0]  path_count_code [gtpp_pkg::PATH_COUNT];
    logic [63:0] path_descriptor [gtpp_pkg::PATH_COUNT];
    logic [15:0] frag_qwords = '0;

    t_qword_label expected_labels[$];

    // Qwords the stimulus still owes each path before it goes idle again.
    int gen_words_left[gtpp_pkg::PATH_COUNT];

    int  fail_count    = 0;
    int  sent_count    = 0;
    int  checked_count = 0;
    int  kinds_checked[5];
    int  idle_cycles   = 0;
    int  burst_left    = 0;
    bit  gaps_on       = 1'b0;
    bit  rx_stalls     = 1'b0;
    bit  hold_request  = 1'b0;

    graphics_tag_packet_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        for (int p = 0; p < gtpp_pkg::PATH_COUNT; p++) begin
            path_loops[p]      = '0;
            path_reg_pos[p]    = '0;
            path_eop[p]        = 1'b1;
            path_mode[p]       = gtpp_pkg::MODE_PACKED;
            path_count_code[p] = '0;
            path_descriptor[p] = '0;
            gen_words_left[p]  = 0;
        end
        for (int k = 0; k < 5; k++) kinds_checked[k] = 0;
    end

    // Count code zero stands for a full list of sixteen registers.
    function automatic int regs_in_list(input logic [3:0] code);
        return (code == 4'd0) ? int'(gtpp_pkg::MAX_REGS) : int'(code);
    endfunction

    function automatic logic [3:0] current_reg(input int p);
        return path_descriptor[p][4 * path_reg_pos[p] +: 4];
    endfunction

    // Step to the next register; wrapping the list finishes one loop.
    function automatic void next_register(input int p);
        if (int'(path_reg_pos[p]) + 1 >= regs_in_list(path_count_code[p])) begin
            path_reg_pos[p] = '0;
            if (path_loops[p] != 0) path_loops[p]--;
        end else begin
            path_reg_pos[p]++;
        end
    endfunction

    // Works out the labels of one accepted qword and advances the path state.
    function automatic t_qword_label label_qword(input logic [1:0] sel, input logic [63:0] lo,
                                                 input logic [63:0] hi, input logic frag_last);
        t_qword_label r;
        int p;
        p = (int'(sel) >= gtpp_pkg::PATH_COUNT) ? gtpp_pkg::PATH_COUNT - 1 : int'(sel);
        r.kind         = gtpp_pkg::KIND_TAG;
        r.path         = 2'(p);
        r.reg_first    = '0;
        r.reg_second   = '0;
        r.second_valid = 1'b0;
        r.data_low     = lo;
        r.data_high    = hi;
        if (path_loops[p] == 0) begin
            // An idle path reads a tag.
            path_loops[p]      = lo[14:0];
            path_eop[p]        = lo[15];
            path_mode[p]       = gtpp_pkg::t_data_mode'(lo[59:58]);
            path_count_code[p] = lo[63:60];
            path_descriptor[p] = hi;
            path_reg_pos[p]    = '0;
        end else if (path_mode[p] == gtpp_pkg::MODE_PACKED) begin
            if (current_reg(p) == gtpp_pkg::ADDR_DATA_REG) begin
                r.kind      = gtpp_pkg::KIND_ADDR_DATA;
                r.reg_first = hi[7:0];
            end else begin
                r.kind      = gtpp_pkg::KIND_PACKED;
                r.reg_first = {4'd0, current_reg(p)};
            end
            next_register(p);
        end else if (path_mode[p] == gtpp_pkg::MODE_REGLIST) begin
            r.kind      = gtpp_pkg::KIND_REGLIST;
            r.reg_first = {4'd0, current_reg(p)};
            next_register(p);
            // The upper half is padding once the last loop is used up.
            if (path_loops[p] != 0) begin
                r.reg_second   = current_reg(p);
                r.second_valid = 1'b1;
                next_register(p);
            end
        end else begin
            r.kind = gtpp_pkg::KIND_IMAGE;
            path_loops[p]--;
        end
        r.packet_done = path_eop[p] && (path_loops[p] == 0);
        if (frag_qwords != gtpp_pkg::FRAG_MAX) frag_qwords++;
        r.fragment_count = frag_qwords;
        if (frag_last) frag_qwords = '0;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Predict each accepted request, then compare each accepted result with the oldest label.
    always @(posedge i_clk) begin : result_check
        t_qword_label want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_labels.push_back(label_qword(s_axis_tuser, s_axis_tdata[63:0],
                                                  s_axis_tdata[127:64], s_axis_tlast));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            checked_count++;
            if (m_axis_tuser[2:0] < 3'd5) kinds_checked[m_axis_tuser[2:0]]++;
            if (expected_labels.size() == 0) begin
                $error("result arrived with no request waiting");
                fail_count++;
            end else begin
                want = expected_labels.pop_front();
                check_field("item_kind", 64'(want.kind), 64'(m_axis_tuser[2:0]));
                check_field("path_out", 64'(want.path), 64'(m_axis_tuser[4:3]));
                check_field("reg_first", 64'(want.reg_first), 64'(m_axis_tdata[7:0]));
                check_field("reg_second", 64'(want.reg_second), 64'(m_axis_tdata[11:8]));
                check_field("second_valid", 64'(want.second_valid), 64'(m_axis_tuser[5]));
                check_field("data_low", want.data_low, m_axis_tdata[75:12]);
                check_field("data_high", want.data_high, m_axis_tdata[139:76]);
                check_field("packet_done", 64'(want.packet_done), 64'(m_axis_tlast));
                check_field("fragment_count", 64'(want.fragment_count),
                            64'(m_axis_tdata[155:140]));
            end
        end
    end

    // Ends the run when neither side has moved a request for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: always ready, alternating ready and stall runs, or one long hold-off.
    initial begin : rx_pattern
        int  run_left;
        bit  stalled;
        run_left = 0;
        stalled  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                run_left = 0;
                stalled  = 1'b0;
            end else if (!rx_stalls) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalled  = !stalled;
                    run_left = stalled ? $urandom_range(1, 6) : $urandom_range(1, 10);
                end
                run_left--;
                m_axis_tready <= !stalled;
            end
        end
    end

    function automatic logic [63:0] make_tag(input logic [14:0] loops, input logic eop,
                                             input gtpp_pkg::t_data_mode mode,
                                             input logic [3:0] code,
                                             input logic [63:0] filler);
        return {code, mode, filler[57:16], eop, loops};
    endfunction

    function automatic int words_per_packet(input logic [14:0] loops,
                                            input gtpp_pkg::t_data_mode mode,
                                            input logic [3:0] code);
        if (mode == gtpp_pkg::MODE_PACKED) return int'(loops) * regs_in_list(code);
        if (mode == gtpp_pkg::MODE_REGLIST) return (int'(loops) * regs_in_list(code) + 1) / 2;
        return int'(loops);
    endfunction

    // Offers one qword in bursts, with random gaps when gaps are on, and returns once it is accepted.
    task automatic send_qword(input logic [1:0] sel, input logic [63:0] lo,
                              input logic [63:0] hi, input logic frag_last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        s_axis_tuser  <= sel;
        s_axis_tlast  <= frag_last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    // Sender pause: no request offered until every result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_labels.size() != 0) @(posedge i_clk);
    endtask

    // Next qword of a well-formed stream: a tag on an idle path, else data for its packet.
    task automatic send_generated(input bit frag_ends, input bit force_last);
        int          p;
        logic [1:0]  sel;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [14:0] loops;
        logic [3:0]  code;
        gtpp_pkg::t_data_mode mode;
        p   = $urandom_range(0, gtpp_pkg::PATH_COUNT - 1);
        sel = 2'(p);
        // An out-of-range selector lands on the last path.
        if (p == gtpp_pkg::PATH_COUNT - 1 && $urandom_range(0, 5) == 0) sel = 2'd3;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if (gen_words_left[p] == 0) begin
            case ($urandom_range(0, 9))
                0:       loops = '0;
                1:       loops = 15'($urandom_range(4, 12));
                default: loops = 15'($urandom_range(1, 3));
            endcase
            code = 4'($urandom);
            mode = gtpp_pkg::t_data_mode'($urandom_range(0, 3));
            lo   = make_tag(loops, lo[15], mode, code, lo);
            // Seed the register list with address-data entries now and then.
            if ($urandom_range(0, 2) == 0) begin
                for (int i = 0; i < 16; i++)
                    if ($urandom_range(0, 3) == 0) hi[4 * i +: 4] = gtpp_pkg::ADDR_DATA_REG;
            end
            gen_words_left[p] = words_per_packet(loops, mode, code);
        end else begin
            gen_words_left[p]--;
        end
        send_qword(sel, lo, hi, force_last || (frag_ends && $urandom_range(0, 11) == 0));
    endtask

    // Packed list 1, 0xe, 0xf: plain write, address-data write, plain write of register 15.
    task automatic test_packed_mode();
        send_qword(2'd0, make_tag(15'd1, 1'b1, gtpp_pkg::MODE_PACKED, 4'd3, '0),
                   64'hffff_ffff_ffff_ffe1, 1'b0);
        send_qword(2'd0, '0, '0, 1'b0);
        send_qword(2'd0, '1, '1, 1'b0);
        send_qword(2'd0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    endtask

    // Odd list of three pads the last pair; a count code of zero walks all sixteen registers.
    task automatic test_reglist_mode();
        send_qword(2'd1, make_tag(15'd1, 1'b1, gtpp_pkg::MODE_REGLIST, 4'd3, '1),
                   64'h0000_0000_0000_0e52, 1'b0);
        send_qword(2'd1, '1, '0, 1'b0);
        send_qword(2'd1, '0, '1, 1'b0);
        send_qword(2'd1, make_tag(15'd1, 1'b0, gtpp_pkg::MODE_REGLIST, 4'd0, '0),
                   64'hfedc_ba98_7654_3210, 1'b0);
        for (int i = 0; i < 8; i++)
            send_qword(2'd1, {$urandom, $urandom}, {$urandom, $urandom}, i == 7);
    endtask

    // Both image codes, the second through an out-of-range path selector.
    task automatic test_image_mode();
        send_qword(2'd2, make_tag(15'd2, 1'b0, gtpp_pkg::MODE_IMAGE, 4'd5, '1), '1, 1'b0);
        send_qword(2'd2, '1, '1, 1'b0);
        send_qword(2'd2, '0, '0, 1'b0);
        send_qword(2'd3, make_tag(15'd1, 1'b1, gtpp_pkg::MODE_IMAGE_B, 4'd0, '0), '0, 1'b0);
        send_qword(2'd3, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    endtask

    // Tags with no loops leave the path idle; packet_done follows their end-of-packet bit.
    task automatic test_zero_loop_tags();
        send_qword(2'd0, make_tag(15'd0, 1'b1, gtpp_pkg::MODE_IMAGE_B, 4'hf, '1), '1, 1'b0);
        send_qword(2'd0, make_tag(15'd0, 1'b0, gtpp_pkg::MODE_REGLIST, 4'h0, '0), '0, 1'b1);
    endtask

    task automatic test_random_traffic(input int count, input bit gaps, input bit stalls);
        gaps_on   = gaps;
        rx_stalls = stalls;
        repeat (count) send_generated(1'b1, 1'b0);
    endtask

    // Long hold-off on the result side fills the block and stalls its input.
    task automatic test_backpressure_hold();
        gaps_on      = 1'b0;
        rx_stalls    = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_generated(1'b1, 1'b0);
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_packed_mode();
        test_reglist_mode();
        test_image_mode();
        test_zero_loop_tags();
        test_random_traffic(300, 1'b0, 1'b0);
        test_random_traffic(500, 1'b1, 1'b1);
        test_backpressure_hold();
        test_random_traffic(260, 1'b1, 1'b1);

        wait_for_results();
        rx_stalls = 1'b0;
        repeat (10) @(posedge i_clk);
        if (expected_labels.size() != 0) begin
            $error("%0d results never arrived", expected_labels.size());
            fail_count++;
        end

        $display("Sent %0d qwords on all paths, with idle gaps, result stalls and a hold-off;",
                 sent_count);
        $display("results %0d: tag %0d, packed %0d, addr-data %0d, reglist %0d, image %0d.",
                 checked_count, kinds_checked[gtpp_pkg::KIND_TAG],
                 kinds_checked[gtpp_pkg::KIND_PACKED], kinds_checked[gtpp_pkg::KIND_ADDR_DATA],
                 kinds_checked[gtpp_pkg::KIND_REGLIST], kinds_checked[gtpp_pkg::KIND_IMAGE]);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
